@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the PackBits encoder checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define PB_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define PB_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/pbrle_pkg.sv @@
// ---------------------------------------------------------------------------
// pbrle_pkg
// Types, constants and command builders for the PackBits RLE encoder.
// ---------------------------------------------------------------------------
package pbrle_pkg;

   localparam int         LIT_MAX_DEFAULT = 32;
   localparam int         CNT_W           = 6;
   localparam int         CMDQ_DEPTH      = 4;
   localparam logic [7:0] RUN_LIMIT       = 8'd128;
   localparam logic [7:0] EOD_BYTE        = 8'd128;
   localparam logic [8:0] RUN_HDR_BASE    = 9'd257;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       item_last;
      logic       data_end;
   } rsp_payload_type;

   // One back-end command: header byte, then nread bytes from the literal
   // store, then val if has_val.
   typedef struct packed {
      logic [7:0]       head;
      logic [CNT_W-1:0] nread;
      logic             has_val;
      logic [7:0]       val;
      logic             eod;
      logic             last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } cmdq_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_HEAD,
      BK_DATA,
      BK_TAIL
   } back_state_type;

   // Literal chunk: n stored bytes plus an optional trailing byte.
   function automatic cmd_type lit_cmd(logic [CNT_W-1:0] n, logic tail, logic [7:0] val);
      cmd_type c;
      c.head    = {2'b00, n} + {7'd0, tail} - 8'd1;
      c.nread   = n;
      c.has_val = tail;
      c.val     = val;
      c.eod     = 1'b0;
      c.last    = 1'b0;
      return c;
   endfunction

   function automatic cmd_type run_cmd(logic [7:0] len, logic [7:0] val);
      cmd_type c;
      c.head    = 8'(RUN_HDR_BASE - {1'b0, len});
      c.nread   = '0;
      c.has_val = 1'b1;
      c.val     = val;
      c.eod     = 1'b0;
      c.last    = 1'b0;
      return c;
   endfunction

   function automatic cmd_type eod_cmd();
      cmd_type c;
      c.head    = EOD_BYTE;
      c.nread   = '0;
      c.has_val = 1'b0;
      c.val     = 8'd0;
      c.eod     = 1'b1;
      c.last    = 1'b0;
      return c;
   endfunction

endpackage

@@ rtl/pbrle_ram.sv @@
// ---------------------------------------------------------------------------
// pbrle_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ---------------------------------------------------------------------------
module pbrle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/pbrle_queue.sv @@
// ---------------------------------------------------------------------------
// pbrle_queue
// Small command FIFO between the classifier and the byte emitter.
// ---------------------------------------------------------------------------
module pbrle_queue
   import pbrle_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cmd_type         push_data,
   input  logic            pop,
   output cmd_type         head,
   output cmdq_status_type status
);

   localparam int AW = $clog2(CMDQ_DEPTH);
   localparam int CW = $clog2(CMDQ_DEPTH + 1);

   cmd_type         slot_ff [CMDQ_DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            do_push, do_pop;

   assign status.full  = (count_ff == CW'(CMDQ_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/pbrle_front.sv @@
// ---------------------------------------------------------------------------
// pbrle_front
// Classifies each input byte against the held run/literal state, writes the
// literal store and queues up to three emit commands per transaction.
// ---------------------------------------------------------------------------
module pbrle_front
   import pbrle_pkg::*;
#(
   parameter int MAX_LIT = LIT_MAX_DEFAULT,
   localparam int LIT_AW = (MAX_LIT > 1) ? $clog2(MAX_LIT) : 1
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            wr_en,
   output logic [LIT_AW-1:0] wr_addr,
   output logic [7:0]      wr_data,
   output logic            cmd_push,
   output cmd_type         cmd_data,
   input  cmdq_status_type q_status,
   input  logic            lit_done
);

   localparam logic [LIT_AW:0] LIT_FULL = (LIT_AW + 1)'(MAX_LIT);

   logic [7:0]        held_ff, held_in;
   logic [7:0]        run_ff, run_in;
   logic [LIT_AW-1:0] cnt_ff, cnt_in;
   logic              lit_busy_ff, lit_busy_in;
   cmd_type           plan_ff [4];
   cmd_type           plan_in [4];
   logic [3:0]        plan_v_ff, plan_v_in;
   cmd_type           slot [4];
   logic [3:0]        slot_v;
   logic              slot_wr;
   logic [7:0]        run_inc;
   logic [1:0]        sel;
   logic              accept;
   logic              seen;

   // Holding a single byte may mean a store write, which must wait until the
   // back end has finished reading the previous chunk.
   assign req_stall = (plan_v_ff != 4'd0) || ((run_ff == 8'd1) && lit_busy_ff);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      held_in = held_ff;
      run_in  = run_ff;
      cnt_in  = cnt_ff;
      slot_wr = 1'b0;
      slot_v  = 4'd0;
      run_inc = run_ff + 8'd1;
      seen    = 1'b0;
      for (int i = 0; i < 4; i++) begin
         slot[i] = eod_cmd();
      end

      if (run_ff == 8'd0) begin
         held_in = req_payload.data_byte;
         run_in  = 8'd1;
      end else if (req_payload.data_byte == held_ff) begin
         if (run_ff == 8'd1) begin
            if (cnt_ff != '0) begin
               slot[0]   = lit_cmd(CNT_W'(cnt_ff), 1'b0, 8'd0);
               slot_v[0] = 1'b1;
            end
            cnt_in = '0;
         end
         if (run_inc >= RUN_LIMIT) begin
            slot[1]   = run_cmd(run_inc, held_ff);
            slot_v[1] = 1'b1;
            run_in    = 8'd0;
         end else begin
            run_in = run_inc;
         end
      end else begin
         if (run_ff >= 8'd2) begin
            slot[0]   = run_cmd(run_ff, held_ff);
            slot_v[0] = 1'b1;
         end else if (({1'b0, cnt_ff} + (LIT_AW + 1)'(1)) >= LIT_FULL) begin
            // chunk fills with the held byte: send it as the trailing byte
            slot[0]   = lit_cmd(CNT_W'(cnt_ff), 1'b1, held_ff);
            slot_v[0] = 1'b1;
            cnt_in    = '0;
         end else begin
            slot_wr = 1'b1;
            cnt_in  = cnt_ff + LIT_AW'(1);
         end
         held_in = req_payload.data_byte;
         run_in  = 8'd1;
      end

      if (req_payload.end_of_stream) begin
         if (run_in >= 8'd2) begin
            slot[2]   = run_cmd(run_in, held_in);
            slot_v[2] = 1'b1;
         end else if (run_in == 8'd1) begin
            slot[2]   = lit_cmd(CNT_W'(cnt_in), 1'b1, held_in);
            slot_v[2] = 1'b1;
         end
         slot[3]   = eod_cmd();
         slot_v[3] = 1'b1;
         held_in   = 8'd0;
         run_in    = 8'd0;
         cnt_in    = '0;
      end

      for (int i = 3; i >= 0; i--) begin
         slot[i].last = slot_v[i] && !seen;
         seen         = seen || slot_v[i];
      end
   end

   // lowest pending slot goes first
   always_comb begin
      sel = 2'd0;
      for (int i = 3; i >= 0; i--) begin
         if (plan_v_ff[i]) begin
            sel = 2'(i);
         end
      end
   end

   assign cmd_push = (plan_v_ff != 4'd0) && !q_status.full;
   assign cmd_data = plan_ff[sel];
   assign wr_en    = accept && slot_wr;
   assign wr_addr  = cnt_ff;
   assign wr_data  = held_ff;

   always_comb begin
      plan_v_in = plan_v_ff;
      for (int i = 0; i < 4; i++) begin
         plan_in[i] = plan_ff[i];
      end
      if (accept) begin
         plan_v_in = slot_v;
         for (int i = 0; i < 4; i++) begin
            plan_in[i] = slot[i];
         end
      end else if (cmd_push) begin
         plan_v_in[sel] = 1'b0;
      end

      lit_busy_in = lit_busy_ff;
      if (cmd_push && (cmd_data.nread != '0)) begin
         lit_busy_in = 1'b1;
      end else if (lit_done) begin
         lit_busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= 8'd0;
         run_ff      <= 8'd0;
         cnt_ff      <= '0;
         plan_v_ff   <= 4'd0;
         lit_busy_ff <= 1'b0;
      end else begin
         if (accept) begin
            held_ff <= held_in;
            run_ff  <= run_in;
            cnt_ff  <= cnt_in;
         end
         plan_v_ff   <= plan_v_in;
         lit_busy_ff <= lit_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 4; i++) begin
         plan_ff[i] <= plan_in[i];
      end
   end

endmodule

@@ rtl/pbrle_back.sv @@
// ---------------------------------------------------------------------------
// pbrle_back
// Byte emitter: expands queued commands into header, stored literal bytes
// and trailing value, through a registered output stage.
// ---------------------------------------------------------------------------
module pbrle_back
   import pbrle_pkg::*;
#(
   parameter int MAX_LIT = LIT_MAX_DEFAULT,
   localparam int LIT_AW = (MAX_LIT > 1) ? $clog2(MAX_LIT) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  cmdq_status_type   q_status,
   input  cmd_type           cmd_head,
   output logic              cmd_pop,
   output logic [LIT_AW-1:0] rd_addr,
   input  logic [7:0]        rd_data,
   output logic              lit_done,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_payload_type   rsp_payload
);

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [LIT_AW-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_payload_ff, rsp_payload_in;
   logic              out_free;
   logic              at_end;
   logic              emit;
   rsp_payload_type   emit_payload;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign at_end   = (CNT_W'(idx_ff) == (cmd_ff.nread - CNT_W'(1)));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_status.empty) begin
               state_in = BK_HEAD;
            end
         end
         BK_HEAD: begin
            if (out_free) begin
               if (cmd_ff.nread != '0) begin
                  state_in = BK_DATA;
               end else if (cmd_ff.has_val) begin
                  state_in = BK_TAIL;
               end else begin
                  state_in = BK_IDLE;
               end
            end
         end
         BK_DATA: begin
            if (out_free && at_end) begin
               state_in = cmd_ff.has_val ? BK_TAIL : BK_IDLE;
            end
         end
         BK_TAIL: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // Read address is idx_in, the value idx_ff takes next, so rd_data always holds entry idx_ff.
   always_comb begin
      cmd_pop      = 1'b0;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      emit         = 1'b0;
      lit_done     = 1'b0;
      emit_payload = '{out_byte: cmd_ff.head, item_last: 1'b0, data_end: 1'b0};
      case (state_ff)
         BK_IDLE: begin
            cmd_pop = !q_status.empty;
            cmd_in  = cmd_head;
            idx_in  = '0;
         end
         BK_HEAD: begin
            emit                   = out_free;
            emit_payload.out_byte  = cmd_ff.head;
            emit_payload.item_last = cmd_ff.last && (cmd_ff.nread == '0) && !cmd_ff.has_val;
            emit_payload.data_end  = cmd_ff.eod;
         end
         BK_DATA: begin
            emit                   = out_free;
            emit_payload.out_byte  = rd_data;
            emit_payload.item_last = cmd_ff.last && at_end && !cmd_ff.has_val;
            lit_done               = out_free && at_end;
            if (out_free) begin
               idx_in = idx_ff + LIT_AW'(1);
            end
         end
         BK_TAIL: begin
            emit                   = out_free;
            emit_payload.out_byte  = cmd_ff.val;
            emit_payload.item_last = cmd_ff.last;
         end
         default: begin
            cmd_pop = 1'b0;
         end
      endcase

      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = emit_payload;
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rd_addr     = idx_in;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      idx_ff         <= idx_in;
      rsp_payload_ff <= rsp_payload_in;
   end

endmodule

@@ rtl/packbits_rle_encoder_unit.sv @@
// ---------------------------------------------------------------------------
// packbits_rle_encoder_unit
// PackBits run-length encoder: byte stream in, encoded byte stream out.
// ---------------------------------------------------------------------------
//  channel | ports                            | direction | moves
//  --------+----------------------------------+-----------+--------------------
//  request | req_valid, req_stall, req_payload| in        | one pixel byte
//  result  | rsp_valid, rsp_stall, rsp_payload| out       | one encoded byte
//
//  A request is taken, then the emit commands it raises (0 to 3) are pushed
//  one at a time into a 4-entry queue while req_stall stays high.
//  The emitter loads each command, then sends one byte per cycle unless
//  rsp_stall holds it; literal bytes stream from the store's read port.
//  While a lone byte is held and a literal chunk is still being read out,
//  req_stall stays high. rsp_stall holds the output register and, through
//  the queue, eventually the input. Reset is synchronous; no clearing pass.
// ---------------------------------------------------------------------------
module packbits_rle_encoder_unit
   import pbrle_pkg::*;
#(
   parameter int MAX_LIT = LIT_MAX_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   localparam int LIT_AW = (MAX_LIT > 1) ? $clog2(MAX_LIT) : 1;

   logic              wr_en;
   logic [LIT_AW-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [LIT_AW-1:0] rd_addr;
   logic [7:0]        rd_data;
   logic              cmd_push;
   cmd_type           cmd_data;
   logic              cmd_pop;
   cmd_type           cmd_head;
   cmdq_status_type   q_status;
   logic              lit_done;

   pbrle_front #(.MAX_LIT(MAX_LIT)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .cmd_push    (cmd_push),
      .cmd_data    (cmd_data),
      .q_status    (q_status),
      .lit_done    (lit_done)
   );

   pbrle_ram #(.WIDTH(8), .DEPTH(MAX_LIT)) u_lit_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pbrle_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .status    (q_status)
   );

   pbrle_back #(.MAX_LIT(MAX_LIT)) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .cmd_head    (cmd_head),
      .cmd_pop     (cmd_pop),
      .rd_addr     (rd_addr),
      .rd_data     (rd_data),
      .lit_done    (lit_done),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ rtl/pbrle_checker.sv @@
// ---------------------------------------------------------------------------
// pbrle_checker
// Port-level checks on the encoder's result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pbrle_checker
   import pbrle_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            rsp_valid,
   input  logic            rsp_stall,
   input  rsp_payload_type rsp_payload
);

   `PB_ASSERT(a_rsp_hold_valid, rsp_valid && rsp_stall |=> rsp_valid, "result dropped while stalled")
   `PB_ASSERT(a_rsp_hold_data, rsp_valid && rsp_stall |=> $stable(rsp_payload), "stalled result changed")
   `PB_ASSERT(a_eod_form, rsp_valid && rsp_payload.data_end |-> rsp_payload.item_last && (rsp_payload.out_byte == EOD_BYTE), "bad end-of-data transaction")
   `PB_ASSERT_RST(a_reset_quiet, reset |=> !rsp_valid, "result shown straight after reset")

endmodule

bind packbits_rle_encoder_unit pbrle_checker u_checker (.*);

@@ test/packbits_rle_encoder_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// packbits_rle_encoder_unit_tb
// Drives raster byte streams into the PackBits encoder and checks every
// encoded byte against a behavioural encoder kept in step with the block.
// Covers edge values, the run and literal length limits, random images under
// sender idling and receiver stalls, and a long receiver hold-off.
// ---------------------------------------------------------------------------
module packbits_rle_encoder_unit_tb;
   import pbrle_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic            clock;
   logic            reset       = 1'b1;
   logic            req_valid   = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall   = 1'b0;
   rsp_payload_type rsp_payload;

   // behavioural encoder state
   logic [7:0]      held_px;
   logic [7:0]      run_cnt;
   logic [7:0]      lit_buf [LIT_MAX_DEFAULT];
   int              lit_cnt;
   rsp_payload_type step_q [$];
   rsp_payload_type encoded_q [$];

   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   int              hold_left      = 0;
   int              pixel_count    = 0;
   int              mismatch_count = 0;
   int              cycle_count    = 0;
   logic [7:0]      last_px        = 8'd0;

   packbits_rle_encoder_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---- behavioural encoder ----
   task automatic put_encoded(input logic [7:0] b, input logic eod);
      rsp_payload_type e;
      e.out_byte  = b;
      e.item_last = 1'b0;
      e.data_end  = eod;
      step_q = {step_q, e};
   endtask

   task automatic flush_literal();
      if (lit_cnt != 0) begin
         put_encoded(8'(lit_cnt - 1), 1'b0);
         for (int i = 0; i < lit_cnt; i++)
            put_encoded(lit_buf[i], 1'b0);
         lit_cnt = 0;
      end
   endtask

   task automatic flush_run();
      put_encoded(8'(RUN_HDR_BASE - {1'b0, run_cnt}), 1'b0);
      put_encoded(held_px, 1'b0);
      run_cnt = 8'd0;
   endtask

   task automatic add_literal(input logic [7:0] b);
      if (lit_cnt < LIT_MAX_DEFAULT)
         lit_buf[lit_cnt] = b;
      lit_cnt++;
      if (lit_cnt >= LIT_MAX_DEFAULT)
         flush_literal();
   endtask

   task automatic encode_pixel(input logic [7:0] b, input logic eos);
      step_q = {};
      if (run_cnt == 8'd0) begin
         held_px = b;
         run_cnt = 8'd1;
      end else if (b == held_px) begin
         // second copy turns the held byte into a run: literals go first
         if (run_cnt == 8'd1)
            flush_literal();
         run_cnt = run_cnt + 8'd1;
         if (run_cnt >= RUN_LIMIT)
            flush_run();
      end else begin
         if (run_cnt >= 8'd2)
            flush_run();
         else
            add_literal(held_px);
         held_px = b;
         run_cnt = 8'd1;
      end
      if (eos) begin
         if (run_cnt >= 8'd2) begin
            flush_run();
         end else if (run_cnt == 8'd1) begin
            add_literal(held_px);
            run_cnt = 8'd0;
         end
         flush_literal();
         put_encoded(EOD_BYTE, 1'b1);
         held_px = 8'd0;
         run_cnt = 8'd0;
         lit_cnt = 0;
      end
      if (step_q.size() > 0)
         step_q[step_q.size() - 1].item_last = 1'b1;
      encoded_q = {encoded_q, step_q};
   endtask

   // ---- request side ----
   task automatic send_pixel(input logic [7:0] b, input logic eos);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: b, end_of_stream: eos};
      do
         @(posedge clock);
      while (req_stall);
      encode_pixel(b, eos);
      last_px = b;
      pixel_count++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (encoded_q.size() != 0)
         @(posedge clock);
   endtask

   // ---- result side ----
   task automatic report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
   endtask

   initial begin : result_checker
      rsp_payload_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
            if (encoded_q.size() == 0) begin
               report_mismatch("unexpected encoded byte", rsp_payload.out_byte, -1);
            end else begin
               want = encoded_q.pop_front();
               if (rsp_payload.out_byte !== want.out_byte)
                  report_mismatch("out_byte", rsp_payload.out_byte, want.out_byte);
               if (rsp_payload.item_last !== want.item_last)
                  report_mismatch("item_last", rsp_payload.item_last, want.item_last);
               if (rsp_payload.data_end !== want.data_end)
                  report_mismatch("data_end", rsp_payload.data_end, want.data_end);
            end
         end
      end
   end

   // receiver: long hold-off counted down here, random stalls otherwise
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // ---- tests ----
   task automatic test_edge_values();
      send_pixel(8'h00, 1'b1);               // lone byte
      send_pixel(8'hFF, 1'b1);
      send_pixel(8'hA5, 1'b0);               // shortest run
      send_pixel(8'hA5, 1'b1);
      send_pixel(8'h01, 1'b0);               // literal, then a run starts
      send_pixel(8'h02, 1'b0);
      send_pixel(8'h03, 1'b0);
      send_pixel(8'h03, 1'b0);
      send_pixel(8'h03, 1'b1);
      send_pixel(8'h7E, 1'b0);               // run, then literal
      send_pixel(8'h7E, 1'b0);
      send_pixel(8'h7E, 1'b0);
      send_pixel(8'h81, 1'b0);
      send_pixel(8'h55, 1'b0);
      send_pixel(8'hAA, 1'b1);
      send_pixel(8'hFF, 1'b0);               // run, then end marked on a lone byte
      send_pixel(8'hFF, 1'b0);
      send_pixel(8'h00, 1'b1);
   endtask

   task automatic test_run_limit();
      // full-length run goes out on its last byte; the next byte restarts afresh
      for (int i = 0; i < RUN_LIMIT + 1; i++)
         send_pixel(8'hC3, i == RUN_LIMIT);
   endtask

   task automatic test_literal_limit();
      for (int i = 0; i < LIT_MAX_DEFAULT + 1; i++)
         send_pixel(8'(i * 37 + 11), i == LIT_MAX_DEFAULT);
   endtask

   task automatic send_random_image(input int max_len);
      int         len;
      int         sent;
      int         kind;
      int         seg;
      logic [7:0] v;
      len  = $urandom_range(max_len, 1);
      sent = 0;
      while (sent < len) begin
         kind = $urandom_range(9);
         if (kind < 4) begin
            seg = (kind == 0) ? $urandom_range(40, 2) : $urandom_range(6, 2);
            v   = 8'($urandom);
            for (int k = 0; k < seg && sent < len; k++) begin
               send_pixel(v, sent == len - 1);
               sent++;
            end
         end else if (kind < 8) begin
            seg = $urandom_range(8, 1);
            for (int k = 0; k < seg && sent < len; k++) begin
               v = 8'($urandom);
               if (v == last_px)
                  v = v ^ 8'h01;
               send_pixel(v, sent == len - 1);
               sent++;
            end
         end else begin
            // values from a tiny alphabet make accidental short runs
            seg = $urandom_range(6, 1);
            for (int k = 0; k < seg && sent < len; k++) begin
               send_pixel(8'($urandom_range(1)), sent == len - 1);
               sent++;
            end
         end
      end
   endtask

   task automatic test_random_traffic(input int budget, input int s_pct, input int r_pct);
      int stop_at;
      send_idle_pct  = s_pct;
      recv_stall_pct = r_pct;
      stop_at        = pixel_count + budget;
      while (pixel_count < stop_at)
         send_random_image(8);
   endtask

   task automatic test_receiver_hold_off();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 400;
      // short runs back to back fill the command queue while nothing drains
      for (int i = 0; i < 16; i++)
         send_pixel(8'((i >> 1) * 53 + 7), i == 15);
      // sender stays quiet until every encoded byte is out
      wait_for_drain();
      send_random_image(8);
   endtask

   initial begin : stimulus
      held_px = 8'd0;
      run_cnt = 8'd0;
      lit_cnt = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_edge_values();
      test_run_limit();
      test_literal_limit();
      test_random_traffic(8, 0, 0);
      test_random_traffic(8, 60, 0);
      test_random_traffic(8, 0, 60);
      test_random_traffic(8, 14, 14);
      test_receiver_hold_off();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      wait_for_drain();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
